// File: hw/rtl/gda_pkg.sv
// Package for the Gregorian date arithmetic block.
// Holds the sequencer state type, calendar constants and the month length table.
// No dependencies.
`default_nettype none

package gda_pkg;

    localparam int unsigned YearMax    = 9999;
    localparam int unsigned MonthsYear = 12;
    localparam int unsigned Century    = 100;
    // floor(y * CentRecip / 2**CentShift) equals floor(y / 100) for every 14 bit y.
    localparam int unsigned CentRecip  = 5243;
    localparam int unsigned CentShift  = 19;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_REM,
        ST_CHECK,
        ST_DOY,
        ST_ADD,
        ST_DONE
    } gda_state_t;

    // Days in a month; zero for a month code outside 1..12.
    function automatic logic [4:0] month_length(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        begin
            case (mon)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
                4'd2:                                      len = leap ? 5'd29 : 5'd28;
                default:                                   len = 5'd0;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gda_if.sv
// Valid/ready channel interfaces for the request and the result of the date block.
// No dependencies.
`default_nettype none

interface gda_req_if;
    logic        valid;
    logic        ready;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [11:0] days_to_add;
    logic [4:0]  other_day;
    logic [3:0]  other_month;
    logic [13:0] other_year;

    modport source (
        output valid, day, month, year, days_to_add, other_day, other_month, other_year,
        input  ready
    );
    modport sink (
        input  valid, day, month, year, days_to_add, other_day, other_month, other_year,
        output ready
    );
endinterface

interface gda_rsp_if;
    logic        valid;
    logic        ready;
    logic [4:0]  sum_day;
    logic [3:0]  sum_month;
    logic [13:0] sum_year;
    logic [8:0]  day_of_year;
    logic        is_less;
    logic        is_equal;
    logic        is_greater;
    logic        error;

    modport source (
        output valid, sum_day, sum_month, sum_year, day_of_year,
               is_less, is_equal, is_greater, error,
        input  ready
    );
    modport sink (
        input  valid, sum_day, sum_month, sum_year, day_of_year,
               is_less, is_equal, is_greater, error,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/gregorian_date_arithmetic.sv
// Gregorian date arithmetic: date plus days, day of year and date compare.
// Depends on gda_pkg and the gda_req_if / gda_rsp_if interfaces.
// One request is worked at a time: the next is taken only once the result of the last
// one is in the output register and the sequencer is back in idle. The day of year
// sum and the month carry loop both step month by month through the shared month
// length unit. Reset clears the sequencer and output valid.
`default_nettype none

module gregorian_date_arithmetic
    import gda_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    gda_req_if.sink       req,
    gda_rsp_if.source     rsp
);

    // Sequencer state.
    gda_state_t state_reg, state_next;

    // Captured request.
    logic [4:0]  d_reg;
    logic [3:0]  m_reg;
    logic [13:0] y_reg;
    logic [11:0] n_reg;
    logic [4:0]  od_reg;
    logic [3:0]  om_reg;
    logic [13:0] oy_reg;

    // Year split into century and year within the century, kept in step with sy_reg.
    logic [7:0]  hi_reg, hi_next;
    logic [6:0]  lo_reg, lo_next;

    // Working values of the loops.
    logic [3:0]  k_reg, k_next;
    logic [8:0]  doy_reg, doy_next;
    logic [12:0] sd_reg, sd_next;
    logic [3:0]  sm_reg, sm_next;
    logic [14:0] sy_reg, sy_next;
    logic        err_reg, err_next;

    // Output register.
    logic        rsp_valid_reg, rsp_valid_next;
    logic [4:0]  o_day_reg;
    logic [3:0]  o_month_reg;
    logic [13:0] o_year_reg;
    logic [8:0]  o_doy_reg;
    logic        o_lt_reg, o_eq_reg, o_gt_reg, o_err_reg;

    logic        accept;
    logic        out_free;
    logic [26:0] recip_prod;
    logic [14:0] cent_prod;
    logic        leap;
    logic [3:0]  cur_month;
    logic [4:0]  mlen;
    logic        cmp_lt, cmp_eq;
    logic        overflow;

    assign accept   = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);

    // The year's century is found by a multiply with the reciprocal of 100, and the
    // remainder by a second multiply in the next cycle.
    assign recip_prod = y_reg * 13'(CentRecip);
    assign cent_prod  = hi_reg * 7'(Century);

    // Leap rule on the split year: a year within the century divisible by 4, or a
    // century year whose century is divisible by 4.
    assign leap = (lo_reg == 7'd0) ? (hi_reg[1:0] == 2'd0) : (lo_reg[1:0] == 2'd0);

    // The shared month length unit looks at the first month during the check, at
    // the running month index during the day of year sum and at the carried month
    // during the advance.
    always_comb
    begin
        case (state_reg)
            ST_CHECK: cur_month = m_reg;
            ST_DOY:   cur_month = k_reg;
            default:  cur_month = sm_reg;
        endcase
    end

    assign mlen = month_length(cur_month, leap);

    // The comparison works on the raw fields, year first, then month, then day.
    assign cmp_lt = (y_reg < oy_reg) ||
                    ((y_reg == oy_reg) && (m_reg < om_reg)) ||
                    ((y_reg == oy_reg) && (m_reg == om_reg) && (d_reg < od_reg));
    assign cmp_eq = (y_reg == oy_reg) && (m_reg == om_reg) && (d_reg == od_reg);

    assign overflow = (sy_reg > 15'(YearMax));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:   state_next = ST_REM;
            ST_REM:   state_next = ST_CHECK;
            ST_CHECK:
            begin
                if ((d_reg == 5'd0) || (d_reg > mlen))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DOY;
                end
            end
            ST_DOY:
            begin
                if (k_reg >= m_reg)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (sd_reg <= 13'(mlen))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Working values of the sequencer.
    always_comb
    begin
        hi_next  = hi_reg;
        lo_next  = lo_reg;
        k_next   = k_reg;
        doy_next = doy_reg;
        sd_next  = sd_reg;
        sm_next  = sm_reg;
        sy_next  = sy_reg;
        err_next = err_reg;
        case (state_reg)
            ST_DIV:
            begin
                hi_next = recip_prod[CentShift +: 8];
            end
            ST_REM:
            begin
                lo_next = 7'(15'(y_reg) - cent_prod);
            end
            ST_CHECK:
            begin
                err_next = (d_reg == 5'd0) || (d_reg > mlen);
                doy_next = 9'(d_reg);
                k_next   = 4'd1;
                sd_next  = 13'(d_reg) + 13'(n_reg);
                sm_next  = m_reg;
                sy_next  = 15'(y_reg);
            end
            ST_DOY:
            begin
                if (k_reg < m_reg)
                begin
                    doy_next = doy_reg + 9'(mlen);
                    k_next   = k_reg + 4'd1;
                end
            end
            ST_ADD:
            begin
                if (sd_reg > 13'(mlen))
                begin
                    sd_next = sd_reg - 13'(mlen);
                    if (sm_reg >= 4'(MonthsYear))
                    begin
                        // New year: the split year moves along with the full year.
                        sm_next = 4'd1;
                        sy_next = sy_reg + 15'd1;
                        if (lo_reg == 7'(Century - 1))
                        begin
                            lo_next = 7'd0;
                            hi_next = hi_reg + 8'd1;
                        end
                        else
                        begin
                            lo_next = lo_reg + 7'd1;
                        end
                    end
                    else
                    begin
                        sm_next = sm_reg + 4'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if ((state_reg == ST_DONE) && out_free)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d_reg  <= req.day;
            m_reg  <= req.month;
            y_reg  <= req.year;
            n_reg  <= req.days_to_add;
            od_reg <= req.other_day;
            om_reg <= req.other_month;
            oy_reg <= req.other_year;
        end
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        k_reg   <= k_next;
        doy_reg <= doy_next;
        sd_reg  <= sd_next;
        sm_reg  <= sm_next;
        sy_reg  <= sy_next;
        err_reg <= err_next;
        if ((state_reg == ST_DONE) && out_free)
        begin
            o_lt_reg <= cmp_lt;
            o_eq_reg <= cmp_eq;
            o_gt_reg <= !cmp_lt && !cmp_eq;
            if (err_reg)
            begin
                // Invalid first date: every date field of the result is zero.
                o_day_reg   <= 5'd0;
                o_month_reg <= 4'd0;
                o_year_reg  <= 14'd0;
                o_doy_reg   <= 9'd0;
                o_err_reg   <= 1'b1;
            end
            else if (overflow)
            begin
                // Advance past the last year: the sum is zeroed, day of year stays.
                o_day_reg   <= 5'd0;
                o_month_reg <= 4'd0;
                o_year_reg  <= 14'd0;
                o_doy_reg   <= doy_reg;
                o_err_reg   <= 1'b1;
            end
            else
            begin
                o_day_reg   <= sd_reg[4:0];
                o_month_reg <= sm_reg;
                o_year_reg  <= sy_reg[13:0];
                o_doy_reg   <= doy_reg;
                o_err_reg   <= 1'b0;
            end
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.sum_day     = o_day_reg;
    assign rsp.sum_month   = o_month_reg;
    assign rsp.sum_year    = o_year_reg;
    assign rsp.day_of_year = o_doy_reg;
    assign rsp.is_less     = o_lt_reg;
    assign rsp.is_equal    = o_eq_reg;
    assign rsp.is_greater  = o_gt_reg;
    assign rsp.error       = o_err_reg;

    // An accepted request always starts the century split.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_DIV))
        else $error("accepted request did not start the sequencer");

    // Exactly one comparison outcome is reported.
    a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> $onehot({o_lt_reg, o_eq_reg, o_gt_reg}))
        else $error("comparison outcome not one-hot");

    // A result without error is a real calendar date.
    a_date: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !o_err_reg) |->
            ((o_month_reg >= 4'd1) && (o_month_reg <= 4'(MonthsYear)) &&
             (o_day_reg >= 5'd1) && (o_doy_reg >= 9'd1)))
        else $error("result without error is not a valid date");

    // The year within the century never leaves its range during the advance.
    a_split: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> (lo_reg < 7'(Century)))
        else $error("year within century out of range");

    // A result held while stalled stays unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |=> (rsp_valid_reg && $stable(o_day_reg) &&
                                           $stable(o_month_reg) && $stable(o_year_reg)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// File: test/gregorian_date_arithmetic_test.sv
// Self-checking testbench for gregorian_date_arithmetic: date plus days, day of year, compare.
// Depends on gda_pkg, the gda_req_if / gda_rsp_if interfaces and the block itself.
// A directed table runs first, then random requests; every result is checked in order.

module gregorian_date_arithmetic_test;

    // One request as the block sees it, at the widths of the request channel.
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [11:0] days_to_add;
        logic [4:0]  other_day;
        logic [3:0]  other_month;
        logic [13:0] other_year;
    } date_req_t;

    // One result, at the widths of the result channel.
    typedef struct packed {
        logic [4:0]  sum_day;
        logic [3:0]  sum_month;
        logic [13:0] sum_year;
        logic [8:0]  day_of_year;
        logic        is_less;
        logic        is_equal;
        logic        is_greater;
        logic        error;
    } date_sum_t;

    // A row of the directed table. Rows with a typed result carry it in want;
    // the others take the result from the date predictor.
    typedef struct packed {
        date_req_t stim;
        logic      typed;
        date_sum_t want;
    } dir_row_t;

    localparam int NumDirected = 24;
    localparam int NumRandom   = 900;
    // Margin after the last pending result; a stray extra result in it is still caught.
    localparam int DrainCycles = 200;
    localparam int LongHold    = 400;
    localparam int CycleLimit  = 1000000;

    logic clk;
    logic rst_n;

    gda_req_if req_ch ();
    gda_rsp_if rsp_ch ();

    gregorian_date_arithmetic dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Expected results, oldest first. A request pushes its result when it is accepted.
    date_sum_t pending_sums[$];
    dir_row_t  directed_rows [NumDirected];

    int  mismatches    = 0;
    int  results_seen  = 0;
    int  cycle_count   = 0;
    // Random idling of both sides is only active while this is set.
    bit  idling_on     = 1'b1;
    // Set by the request side to make the result side hold ready low for the long hold-off (LongHold).
    bit  hold_off_pending = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------

    // Gregorian leap rule: every fourth year, except centuries not divisible by 400.
    function automatic bit leap_year_of(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Days in month m of year y; zero when the month code is out of range.
    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year_of(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Works out the whole result of one request: the advanced date, the day of
    // the year of the first date and the three-way compare of the raw fields.
    function automatic date_sum_t predict_date_sum(input date_req_t r);
        date_sum_t   s;
        int unsigned d, m, y, sd, sm, sy, doy, k;
        s = '0;
        d = r.day;
        m = r.month;
        y = r.year;
        if (m < 1 || m > 12 || d == 0 || d > days_in_month(m, y))
        begin
            // An invalid first date leaves the date fields and day of year at zero.
            s.error = 1'b1;
        end
        else
        begin
            doy = d;
            for (k = 1; k < m; k++)
                doy += days_in_month(k, y);
            s.day_of_year = doy[8:0];

            // Carry the sum one month at a time, rolling the year after December.
            sd = d + r.days_to_add;
            sm = m;
            sy = y;
            while (sd > days_in_month(sm, sy))
            begin
                sd -= days_in_month(sm, sy);
                sm++;
                if (sm > 12)
                begin
                    sm = 1;
                    sy++;
                end
            end
            if (sy > gda_pkg::YearMax)
            begin
                // Past the last year: flag it, but the day of year still stands.
                s.error = 1'b1;
            end
            else
            begin
                s.sum_day   = sd[4:0];
                s.sum_month = sm[3:0];
                s.sum_year  = sy[13:0];
            end
        end

        // The compare is always done, on raw values and without any validity check.
        s.is_less = (r.year < r.other_year)
                 || (r.year == r.other_year && r.month < r.other_month)
                 || (r.year == r.other_year && r.month == r.other_month
                     && r.day < r.other_day);
        s.is_equal   = (r.day == r.other_day) && (r.month == r.other_month)
                    && (r.year == r.other_year);
        s.is_greater = !s.is_less && !s.is_equal;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Table helpers
    // ------------------------------------------------------------------

    function automatic date_req_t req_of(input int d, input int m, input int y, input int n,
                                         input int od, input int om, input int oy);
        date_req_t r;
        r.day         = 5'(d);
        r.month       = 4'(m);
        r.year        = 14'(y);
        r.days_to_add = 12'(n);
        r.other_day   = 5'(od);
        r.other_month = 4'(om);
        r.other_year  = 14'(oy);
        return r;
    endfunction

    function automatic date_sum_t sum_of(input int sd, input int sm, input int sy,
                                         input int doy, input bit lt, input bit eq,
                                         input bit gt, input bit err);
        date_sum_t s;
        s.sum_day     = 5'(sd);
        s.sum_month   = 4'(sm);
        s.sum_year    = 14'(sy);
        s.day_of_year = 9'(doy);
        s.is_less     = lt;
        s.is_equal    = eq;
        s.is_greater  = gt;
        s.error       = err;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Random requests
    // ------------------------------------------------------------------

    // Most requests carry a valid first date with random content, weighted
    // toward the year limit, century years and month ends. The rest are noise:
    // raw random fields, or a day just past the end of its month, or day zero.
    function automatic date_req_t random_request();
        date_req_t   r;
        int unsigned y, m, pick;
        pick = $urandom_range(0, 99);
        if (pick < 82)
        begin
            case ($urandom_range(0, 9))
                0:       y = $urandom_range(9985, 9999);
                1:       y = $urandom_range(10000, 16383);
                2:       y = 100 * $urandom_range(0, 99);
                default: y = $urandom_range(0, 9999);
            endcase
            m = $urandom_range(1, 12);
            r.year  = 14'(y);
            r.month = 4'(m);
            if ($urandom_range(0, 3) == 0)
                r.day = 5'(days_in_month(m, y));
            else
                r.day = 5'($urandom_range(1, days_in_month(m, y)));
        end
        else if (pick < 91)
        begin
            r.day   = 5'($urandom);
            r.month = 4'($urandom);
            r.year  = 14'($urandom);
        end
        else
        begin
            m = $urandom_range(1, 12);
            y = $urandom_range(0, 9999);
            r.year  = 14'(y);
            r.month = 4'(m);
            r.day   = ($urandom_range(0, 1) == 0) ? 5'(days_in_month(m, y) + 1) : 5'd0;
        end

        // Mostly short additions keep the run quick; the full range still shows up.
        pick = $urandom_range(0, 19);
        if (pick == 0)
            r.days_to_add = 12'hFFF;
        else if (pick < 9)
            r.days_to_add = 12'($urandom_range(0, 40));
        else if (pick < 14)
            r.days_to_add = 12'($urandom_range(0, 400));
        else
            r.days_to_add = 12'($urandom);

        // The comparison date is either the same, off by one in a field, or raw bits.
        r.other_day   = r.day;
        r.other_month = r.month;
        r.other_year  = r.year;
        case ($urandom_range(0, 2))
            0: ;
            1:
            begin
                case ($urandom_range(0, 5))
                    0: r.other_day   = r.day + 5'd1;
                    1: r.other_day   = r.day - 5'd1;
                    2: r.other_month = r.month + 4'd1;
                    3: r.other_month = r.month - 4'd1;
                    4: r.other_year  = r.year + 14'd1;
                    default: r.other_year = r.year - 14'd1;
                endcase
            end
            default:
            begin
                r.other_day   = 5'($urandom);
                r.other_month = 4'($urandom);
                r.other_year  = 14'($urandom);
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one request and holds it until the block takes it. Valid stays high
    // on return, so a back-to-back request does not drop it for a cycle.
    task automatic offer_request(input date_req_t r, input date_sum_t want);
        req_ch.valid       <= 1'b1;
        req_ch.day         <= r.day;
        req_ch.month       <= r.month;
        req_ch.year        <= r.year;
        req_ch.days_to_add <= r.days_to_add;
        req_ch.other_day   <= r.other_day;
        req_ch.other_month <= r.other_month;
        req_ch.other_year  <= r.other_year;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_sums.push_back(want);
    endtask

    // After an accepted request, sometimes leave the channel idle for a burst.
    task automatic request_gap();
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch on result %0d: %s got %0d, expected %0d",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // The ready line alternates between stretches of acceptance and short
    // stalls. One long hold-off, asked for by the request side, lets the block
    // fill its output register and stall its input while requests keep coming.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_off_pending)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (LongHold) @(posedge clk);
                hold_off_pending = 1'b0;
            end
            else if (idling_on && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    // Every accepted result is matched against the oldest pending expectation.
    always @(posedge clk)
    begin : check_results
        date_sum_t got, want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.sum_day     = rsp_ch.sum_day;
            got.sum_month   = rsp_ch.sum_month;
            got.sum_year    = rsp_ch.sum_year;
            got.day_of_year = rsp_ch.day_of_year;
            got.is_less     = rsp_ch.is_less;
            got.is_equal    = rsp_ch.is_equal;
            got.is_greater  = rsp_ch.is_greater;
            got.error       = rsp_ch.error;
            if (pending_sums.size() == 0)
            begin
                report_mismatch("result with no request pending, sum_day", got.sum_day, 0);
            end
            else
            begin
                want = pending_sums.pop_front();
                if (got.sum_day !== want.sum_day)
                    report_mismatch("sum_day", got.sum_day, want.sum_day);
                if (got.sum_month !== want.sum_month)
                    report_mismatch("sum_month", got.sum_month, want.sum_month);
                if (got.sum_year !== want.sum_year)
                    report_mismatch("sum_year", got.sum_year, want.sum_year);
                if (got.day_of_year !== want.day_of_year)
                    report_mismatch("day_of_year", got.day_of_year, want.day_of_year);
                if (got.is_less !== want.is_less)
                    report_mismatch("is_less", got.is_less, want.is_less);
                if (got.is_equal !== want.is_equal)
                    report_mismatch("is_equal", got.is_equal, want.is_equal);
                if (got.is_greater !== want.is_greater)
                    report_mismatch("is_greater", got.is_greater, want.is_greater);
                if (got.error !== want.error)
                    report_mismatch("error", got.error, want.error);
            end
            results_seen++;
        end
    end

    // Hard stop in case the block hangs or stops returning results.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CycleLimit)
        begin
            $display("[gregorian_date_arithmetic] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin
        date_req_t r;
        date_sum_t want;

        rst_n              = 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.day         <= '0;
        req_ch.month       <= '0;
        req_ch.year        <= '0;
        req_ch.days_to_add <= '0;
        req_ch.other_day   <= '0;
        req_ch.other_month <= '0;
        req_ch.other_year  <= '0;

        // Directed table. Typed rows are results that follow from the calendar
        // at a glance; the rest go through the predictor.
        // First day of year zero, which is a leap year by the 400 rule.
        directed_rows[0]  = '{req_of(1, 1, 0, 0, 1, 1, 0), 1'b1,
                              sum_of(1, 1, 0, 1, 0, 1, 0, 0)};
        // Last valid day, nothing added.
        directed_rows[1]  = '{req_of(31, 12, 9999, 0, 31, 12, 9999), 1'b1,
                              sum_of(31, 12, 9999, 365, 0, 1, 0, 0)};
        // One day past the last valid day overflows the year.
        directed_rows[2]  = '{req_of(31, 12, 9999, 1, 1, 1, 0), 1'b1,
                              sum_of(0, 0, 0, 365, 0, 0, 1, 1)};
        // A first year already above the limit is an overflow, day of year kept.
        directed_rows[3]  = '{req_of(1, 1, 10000, 0, 1, 1, 10000), 1'b1,
                              sum_of(0, 0, 0, 1, 0, 1, 0, 1)};
        // February 29 in a century that is not a leap year is invalid.
        directed_rows[4]  = '{req_of(29, 2, 1900, 0, 29, 2, 1900), 1'b1,
                              sum_of(0, 0, 0, 0, 0, 1, 0, 1)};
        // Month zero is invalid; the compare still runs.
        directed_rows[5]  = '{req_of(1, 0, 2000, 5, 1, 1, 2000), 1'b1,
                              sum_of(0, 0, 0, 0, 1, 0, 0, 1)};
        // Every first-date bit set: month 15 is invalid.
        directed_rows[6]  = '{req_of(31, 15, 16383, 4095, 0, 0, 0), 1'b1,
                              sum_of(0, 0, 0, 0, 0, 0, 1, 1)};
        // Day zero is invalid.
        directed_rows[7]  = '{req_of(0, 1, 2021, 1, 1, 1, 2021), 1'b1,
                              sum_of(0, 0, 0, 0, 1, 0, 0, 1)};
        // April has only 30 days.
        directed_rows[8]  = '{req_of(31, 4, 2021, 0, 30, 4, 2021), 1'b1,
                              sum_of(0, 0, 0, 0, 0, 0, 1, 1)};
        // Last day of a leap year is day 366.
        directed_rows[9]  = '{req_of(31, 12, 2000, 0, 31, 12, 2000), 1'b1,
                              sum_of(31, 12, 2000, 366, 0, 1, 0, 0)};
        // Largest year that is still valid, but not a representable sum.
        directed_rows[10] = '{req_of(1, 1, 16383, 0, 1, 1, 16383), 1'b1,
                              sum_of(0, 0, 0, 1, 0, 1, 0, 1)};
        // Leap day crossings and month ends.
        directed_rows[11] = '{req_of(29, 2, 2000, 0, 1, 3, 2000), 1'b0, '0};
        directed_rows[12] = '{req_of(28, 2, 2024, 1, 29, 2, 2024), 1'b0, '0};
        directed_rows[13] = '{req_of(28, 2, 2023, 1, 1, 3, 2023), 1'b0, '0};
        directed_rows[14] = '{req_of(28, 2, 2100, 1, 28, 2, 2100), 1'b0, '0};
        directed_rows[15] = '{req_of(31, 1, 2021, 1, 31, 1, 2020), 1'b0, '0};
        directed_rows[16] = '{req_of(31, 12, 1999, 1, 1, 1, 2000), 1'b0, '0};
        // Largest addition from the first year, comparison bits all set.
        directed_rows[17] = '{req_of(1, 1, 0, 4095, 31, 15, 16383), 1'b0, '0};
        // Largest additions close to the year limit.
        directed_rows[18] = '{req_of(31, 12, 9987, 4095, 1, 1, 9987), 1'b0, '0};
        directed_rows[19] = '{req_of(1, 1, 9989, 4095, 1, 1, 9988), 1'b0, '0};
        // Compare on each field in turn.
        directed_rows[20] = '{req_of(15, 6, 2020, 100, 16, 6, 2020), 1'b0, '0};
        directed_rows[21] = '{req_of(15, 6, 2020, 366, 15, 5, 2020), 1'b0, '0};
        directed_rows[22] = '{req_of(15, 6, 2020, 1000, 15, 6, 2021), 1'b0, '0};
        directed_rows[23] = '{req_of(30, 11, 2019, 31, 30, 11, 2018), 1'b0, '0};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NumDirected; i++)
        begin
            r    = directed_rows[i].stim;
            want = directed_rows[i].typed ? directed_rows[i].want : predict_date_sum(r);
            offer_request(r, want);
            request_gap();
        end

        for (int i = 0; i < NumRandom; i++)
        begin
            // No idling in a middle window and in the final stretch of the run.
            idling_on = (i < NumRandom - 150) && !(i >= 550 && i < 650);
            if (i == 250)
                hold_off_pending = 1'b1;
            if (i == 450)
            begin
                // Let the block drain completely before the next request. The loop waits on a clock
                // edge before it looks at the queue, so valid is seen low even when nothing is pending.
                req_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_sums.size() != 0);
            end
            r = random_request();
            offer_request(r, predict_date_sum(r));
            request_gap();
        end
        req_ch.valid <= 1'b0;

        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (mismatches == 0)
            $display("[gregorian_date_arithmetic] OK");
        else
            $display("[gregorian_date_arithmetic] ERROR");
        $finish;
    end

endmodule
